[src/wdhba_pkg.sv]
`default_nettype none
package wdhba_pkg;

  localparam int TIME_W  = 38;
  localparam int VOL_W   = 24;
  localparam int VALUE_W = 25;
  localparam int SUM_W   = 40;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCUM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DEV   = 2'd3;

  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  typedef struct packed {
    logic capture;
    logic clear;
    logic commit;
    logic div_load;
    logic div_step;
    logic res_empty;
    logic res_div;
  } wdhba_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic is_acc;
    logic empty;
    logic div_last;
  } wdhba_stat_t;

endpackage
`default_nettype wire

[src/wdhba_ctrl.sv]
`default_nettype none
module wdhba_ctrl import wdhba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire wdhba_stat_t stat,
  output wdhba_cmd_t       cmd,
  output logic             busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (stat.in_clear) begin
            cmd.clear = 1'b1;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // The bin entry read at the transfer is now available.
        if (stat.is_acc) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else if (stat.empty) begin
          cmd.res_empty = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_div = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

[src/wdhba_datapath.sv]
`default_nettype none
module wdhba_datapath import wdhba_pkg::*; #(
  parameter int DAYS       = 7,
  parameter int HOURS      = 24,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wdhba_cmd_t          cmd,
  output wdhba_stat_t              stat,
  input  wire logic                wr_en,
  input  wire logic                wr_index,
  input  wire logic [TIME_W-1:0]   wr_data,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [11:0]         year,
  input  wire logic [3:0]          month,
  input  wire logic [4:0]          day,
  input  wire logic [4:0]          hour,
  input  wire logic [5:0]          minute,
  input  wire logic [5:0]          second,
  input  wire logic [2:0]          day_of_week,
  input  wire logic [VOL_W-1:0]    volume,
  output logic                     done,
  output logic signed [VALUE_W-1:0] value,
  output logic                     empty_res
);

  localparam int NBINS  = DAYS * HOURS;
  localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int ENT_W  = SUM_W + COUNT_BITS;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [TIME_W-1:0] range_start;
  logic [TIME_W-1:0] range_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_end   <= '1;
    end else if (wr_en) begin
      if (wr_index == REG_START) begin
        range_start <= wr_data;
      end else begin
        range_end <= wr_data;
      end
    end
  end

  // Bin address and window check on the incoming item.
  logic [TIME_W-1:0] stamp;
  logic              in_ok;
  logic              in_win;
  logic [7:0]        lin;
  logic [ADDR_W-1:0] addr_in;

  assign stamp   = {year, month, day, hour, minute, second};
  assign in_ok   = (32'(day_of_week) < DAYS) && (32'(hour) < HOURS);
  assign in_win  = (stamp >= range_start) && (stamp <= range_end);
  assign lin     = day_of_week * 8'(HOURS) + {3'b000, hour};
  assign addr_in = in_ok ? lin[ADDR_W-1:0] : '0;

  logic [KIND_W-1:0] kind_q;
  logic              ok_q;
  logic              win_q;
  logic [ADDR_W-1:0] addr_q;
  logic [VOL_W-1:0]  vol_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      ok_q   <= in_ok;
      win_q  <= in_win;
      addr_q <= addr_in;
      vol_q  <= volume;
    end
  end

  // Bin table: entry holds {sum, count}; a bin without its valid bit reads as zero.
  logic [ENT_W-1:0] mem [NBINS];
  logic [ENT_W-1:0] rd_q;
  logic [NBINS-1:0] vld;
  logic             vld_q;

  logic [SUM_W-1:0]      cur_sum;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [SUM_W:0]        new_sum;
  logic                  acc_ok;

  assign cur_sum = vld_q ? rd_q[ENT_W-1:COUNT_BITS] : '0;
  assign cur_cnt = vld_q ? rd_q[COUNT_BITS-1:0] : '0;
  assign new_sum = {1'b0, cur_sum} + {{(SUM_W + 1 - VOL_W){1'b0}}, vol_q};
  assign acc_ok  = ok_q && win_q && (cur_cnt != COUNT_MAX) && !new_sum[SUM_W];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_q <= mem[addr_in];
    end
    if (cmd.commit && acc_ok) begin
      mem[addr_q] <= {new_sum[SUM_W-1:0], cur_cnt + 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vld <= '0;
    end else if (cmd.commit && acc_ok) begin
      vld[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vld_q <= vld[addr_in];
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [SUM_W-1:0]      quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [CNT_W-1:0]      step_cnt;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  qbit;

  assign trial = {rem, quo[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo      <= cur_sum;
      rem      <= '0;
      dvs      <= cur_cnt;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      quo      <= {quo[SUM_W-2:0], qbit};
      rem      <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_empty || cmd.res_div;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_empty) begin
      value     <= '0;
      empty_res <= 1'b1;
    end else if (cmd.res_div) begin
      value     <= (kind_q == KIND_DEV) ? (quo[VALUE_W-1:0] - {1'b0, vol_q})
                                         : quo[VALUE_W-1:0];
      empty_res <= 1'b0;
    end
  end

  assign stat.in_clear = (kind == KIND_CLEAR);
  assign stat.is_acc   = (kind_q == KIND_ACCUM);
  assign stat.empty    = !ok_q || !vld_q;
  assign stat.div_last = (step_cnt == CNT_W'(SUM_W - 1));

endmodule
`default_nettype wire

[src/weekday_hour_binned_average.sv]
// Clear: taken in the transfer cycle, busy never rises; the next item can follow in the next cycle.
// Accumulate: bin read, then read-modify-write of the same bin.
// Read and deviation: done pulses after the look state for an empty bin, and otherwise
// after the 40-step one-bit-per-cycle divider and the final state.
// The receiver cannot stall; each result is shown for one cycle with done high.
// Synchronous reset zeroes the window start, sets the window end to all ones and empties all bins.
`default_nettype none
module weekday_hour_binned_average import wdhba_pkg::*; #(
  parameter int DAYS       = 7,
  parameter int HOURS      = 24,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 wr_en,
  input  wire logic                 wr_index,
  input  wire logic [TIME_W-1:0]    wr_data,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic [11:0]          year,
  input  wire logic [3:0]           month,
  input  wire logic [4:0]           day,
  input  wire logic [4:0]           hour,
  input  wire logic [5:0]           minute,
  input  wire logic [5:0]           second,
  input  wire logic [2:0]           day_of_week,
  input  wire logic [VOL_W-1:0]     volume,
  output logic                      done,
  output logic signed [VALUE_W-1:0] value,
  output logic                      empty_res
);

  wdhba_cmd_t  cmd;
  wdhba_stat_t stat;

  wdhba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  wdhba_datapath #(
    .DAYS       (DAYS),
    .HOURS      (HOURS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .kind        (kind),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .day_of_week (day_of_week),
    .volume      (volume),
    .done        (done),
    .value       (value),
    .empty_res   (empty_res)
  );

endmodule
`default_nettype wire

[tb/weekday_hour_binned_average_tb.sv]
`timescale 1ns / 1ps
module weekday_hour_binned_average_tb;
  import wdhba_pkg::*;

  localparam int DAYS       = 7;
  localparam int HOURS      = 24;
  localparam int COUNT_BITS = 16;
  localparam int BINS       = DAYS * HOURS;
  localparam int COUNT_MAX  = 2 ** COUNT_BITS - 1;
  localparam int SETTLE     = 48;
  localparam int QUIET_MAX  = 2000;
  localparam logic [TIME_W-1:0] TOP_STAMP = {12'hFFF, 4'hF, 5'h1F, 5'd23, 6'h3F, 6'h3F};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [11:0]       year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [2:0]        day_of_week;
    logic [VOL_W-1:0]  volume;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               empty;
  } bin_result_t;

  // Mirror of the sum and count table plus the queue of averages still due.
  class bin_table_model;
    logic [SUM_W-1:0]      sums   [BINS];
    logic [COUNT_BITS-1:0] counts [BINS];
    logic [TIME_W-1:0]     win_lo;
    logic [TIME_W-1:0]     win_hi;
    bin_result_t           due[$];
    int                    bad_count;

    function new();
      win_lo    = '0;
      win_hi    = '1;
      bad_count = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (sums[i]) begin
        sums[i]   = '0;
        counts[i] = '0;
      end
    endfunction

    function void write_reg(logic idx, logic [TIME_W-1:0] data);
      if (idx == REG_START) win_lo = data;
      else win_hi = data;
    endfunction

    function void flag(string what);
      bad_count++;
      if (bad_count <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    function void take_item(item_t it);
      logic [TIME_W-1:0] stamp;
      logic [SUM_W-1:0]  avg;
      logic              in_table;
      int                slot;
      bin_result_t       r;
      if (it.kind == KIND_CLEAR) begin
        wipe();
        return;
      end
      in_table = (it.day_of_week < DAYS) && (it.hour < HOURS);
      slot = in_table ? it.day_of_week * HOURS + it.hour : 0;
      if (it.kind == KIND_ACCUM) begin
        stamp = {it.year, it.month, it.day, it.hour, it.minute, it.second};
        if (in_table && stamp >= win_lo && stamp <= win_hi && counts[slot] != COUNT_MAX &&
            ({1'b0, sums[slot]} + it.volume) < (41'd1 << SUM_W)) begin
          sums[slot]   = sums[slot] + it.volume;
          counts[slot] = counts[slot] + 1'b1;
        end
        return;
      end
      if (in_table && counts[slot] != 0) begin
        avg     = sums[slot] / counts[slot];
        r.empty = 1'b0;
        r.value = (it.kind == KIND_READ) ? avg[VALUE_W-1:0]
                                         : avg[VALUE_W-1:0] - {1'b0, it.volume};
      end else begin
        r.empty = 1'b1;
        r.value = '0;
      end
      due.push_back(r);
    endfunction

    function void check_result(logic [VALUE_W-1:0] v, logic e);
      bin_result_t want;
      if (due.size() == 0) begin
        flag($sformatf("result with nothing due: value %h empty %b", v, e));
        return;
      end
      want = due.pop_front();
      if (v !== want.value || e !== want.empty)
        flag($sformatf("mismatch: value exp %h got %h, empty exp %b got %b",
                       want.value, v, want.empty, e));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      wr_en;
  logic                      wr_index;
  logic [TIME_W-1:0]         wr_data;
  item_t                     drv;
  logic                      done;
  logic signed [VALUE_W-1:0] value;
  logic                      empty_res;

  bin_table_model board;
  logic [7:0]     hot_bins[$];
  int             idle_pct;
  int             quiet;

  weekday_hour_binned_average #(
    .DAYS(DAYS),
    .HOURS(HOURS),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .kind(drv.kind),
    .year(drv.year),
    .month(drv.month),
    .day(drv.day),
    .hour(drv.hour),
    .minute(drv.minute),
    .second(drv.second),
    .day_of_week(drv.day_of_week),
    .volume(drv.volume),
    .done(done),
    .value(value),
    .empty_res(empty_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) board.write_reg(wr_index, wr_data);
      if (start && !busy) board.take_item(drv);
      if (done) board.check_result(value, empty_res);
    end
  end

  // Any transfer, result or register write resets the watchdog.
  always @(posedge clk) begin
    if ((!rst && start && !busy) || (!rst && done) || wr_en) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic item_t make_item(logic [KIND_W-1:0] k, logic [TIME_W-1:0] stamp,
                                      logic [2:0] dow, logic [VOL_W-1:0] vol);
    item_t it;
    it.kind = k;
    {it.year, it.month, it.day, it.hour, it.minute, it.second} = stamp;
    it.day_of_week = dow;
    it.volume      = vol;
    return it;
  endfunction

  function automatic logic [TIME_W-1:0] hour_stamp(logic [4:0] h);
    return {21'd0, h, 12'd0};
  endfunction

  function automatic item_t random_item();
    item_t             it;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] stamp;
    logic [63:0]       span;
    logic [KIND_W-1:0] k;
    logic [VOL_W-1:0]  vol;
    int                roll;
    lo   = board.win_lo;
    hi   = board.win_hi;
    gap  = hi - lo;
    span = {26'd0, gap} + 64'd1;
    roll = $urandom_range(99);
    if (roll < 3) k = KIND_CLEAR;
    else if (roll < 50) k = KIND_ACCUM;
    else if (roll < 75) k = KIND_READ;
    else k = KIND_DEV;
    // Stamps cluster on and just outside the window edges; the rest fall inside the window or anywhere.
    case ($urandom_range(9))
      0: stamp = lo;
      1: stamp = lo - 1'b1;
      2: stamp = hi;
      3: stamp = hi + 1'b1;
      4, 5, 6: stamp = lo + TIME_W'({$urandom, $urandom} % span);
      default: stamp = TIME_W'({$urandom, $urandom});
    endcase
    case ($urandom_range(9))
      0: vol = '0;
      1: vol = '1;
      2, 3: vol = VOL_W'($urandom_range(4095));
      default: vol = VOL_W'($urandom);
    endcase
    it = make_item(k, stamp, 3'($urandom_range(7)), vol);
    // Steer most queries and many accumulates onto a few recently used bins.
    if (hot_bins.size() != 0 && $urandom_range(99) < (k == KIND_ACCUM ? 50 : 75)) begin
      {it.day_of_week, it.hour} = hot_bins[$urandom_range(hot_bins.size() - 1)];
    end else if (k == KIND_ACCUM) begin
      hot_bins.push_back({it.day_of_week, it.hour});
      if (hot_bins.size() > 8) void'(hot_bins.pop_front());
    end
    return it;
  endfunction

  task automatic send(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    drv   <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
    wr_en    <= 1'b1;
    wr_index <= REG_START;
    wr_data  <= lo;
    @(posedge clk);
    wr_index <= REG_END;
    wr_data  <= hi;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int pct, input logic [TIME_W-1:0] lo,
                           input logic [TIME_W-1:0] hi, input int n);
    logic [TIME_W-1:0] edges[4];
    drain();
    set_window(lo, hi);
    idle_pct = pct;
    edges = '{lo - 1'b1, lo, hi, hi + 1'b1};
    foreach (edges[i]) begin
      send(make_item(KIND_ACCUM, edges[i], 3'd3, VOL_W'($urandom)));
      send(make_item(KIND_READ, edges[i], 3'd3, '0));
    end
    repeat (n) send(random_item());
  endtask

  initial begin
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    board    = new();
    rst      = 1'b1;
    start    = 1'b0;
    wr_en    = 1'b0;
    wr_index = REG_START;
    wr_data  = '0;
    drv      = '0;
    idle_pct = 0;
    quiet    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send(make_item(KIND_READ, '0, 3'd0, '0));
    send(make_item(KIND_DEV, '0, 3'd0, '1));
    send(make_item(KIND_ACCUM, '0, 3'd0, '1));
    send(make_item(KIND_ACCUM, '0, 3'd0, 24'd1));
    send(make_item(KIND_READ, '0, 3'd0, '0));
    send(make_item(KIND_DEV, '0, 3'd0, '1));
    send(make_item(KIND_DEV, '0, 3'd0, '0));
    send(make_item(KIND_ACCUM, TOP_STAMP, 3'd6, '0));
    send(make_item(KIND_ACCUM, TOP_STAMP, 3'd6, 24'h000080));
    send(make_item(KIND_READ, TOP_STAMP, 3'd6, '0));
    send(make_item(KIND_DEV, TOP_STAMP, 3'd6, '1));
    // Bins outside the table: weekday 7 and hours 24 and up.
    send(make_item(KIND_ACCUM, hour_stamp(5), 3'd7, '1));
    send(make_item(KIND_READ, hour_stamp(5), 3'd7, '0));
    send(make_item(KIND_ACCUM, hour_stamp(24), 3'd2, '1));
    send(make_item(KIND_READ, hour_stamp(31), 3'd2, '0));
    send(make_item(KIND_DEV, hour_stamp(24), 3'd7, '1));
    send(make_item(KIND_CLEAR, '1, 3'd7, '1));
    send(make_item(KIND_CLEAR, '0, 3'd0, '0));
    send(make_item(KIND_READ, '0, 3'd0, '0));
    send(make_item(KIND_DEV, TOP_STAMP, 3'd6, '1));
    repeat (120) send(random_item());

    lo = TIME_W'({$urandom, $urandom});
    hi = lo + TIME_W'({$urandom_range(63), $urandom});
    if (hi < lo) hi = '1;
    run_phase(63, lo, hi, 300);
    run_phase(0, '0, '0, 60);

    // Pile many accumulates onto one bin, add a few maximum volumes and read it back.
    drain();
    set_window('0, '1);
    idle_pct = 0;
    send(make_item(KIND_CLEAR, '0, 3'd0, '0));
    repeat (40) send(make_item(KIND_ACCUM, hour_stamp(10), 3'd4, 24'h000100));
    repeat (3) send(make_item(KIND_ACCUM, hour_stamp(10), 3'd4, '1));
    send(make_item(KIND_READ, hour_stamp(10), 3'd4, '0));
    send(make_item(KIND_DEV, hour_stamp(10), 3'd4, '1));

    run_phase(12, '1, '1, 60);
    lo = TIME_W'({$urandom, $urandom}) | (38'd1 << 37);
    run_phase(12, lo, lo - TIME_W'($urandom_range(1, 1 << 20)), 60);
    run_phase(63, '0, '1, 250);
    lo = TIME_W'({$urandom, $urandom}) >> 1;
    run_phase(0, lo, lo + (38'd1 << 34), 100);

    drain();
    if (board.bad_count == 0 && board.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
